// ===== rtl/core/dwarfptr_pkg.sv =====
// Package for the DWARF encoded pointer decoder: encoding codes, status codes,
// per-field state and result types. No dependencies.
package dwarfptr_pkg;

    localparam int POINTER_BYTES = 8;
    localparam int MAX_LEB_BYTES = 10;

    localparam logic [7:0] ENC_OMIT = 8'hFF;

    localparam logic [3:0] FMT_ABSPTR  = 4'h0;
    localparam logic [3:0] FMT_ULEB128 = 4'h1;
    localparam logic [3:0] FMT_UDATA2  = 4'h2;
    localparam logic [3:0] FMT_UDATA4  = 4'h3;
    localparam logic [3:0] FMT_UDATA8  = 4'h4;
    localparam logic [3:0] FMT_SLEB128 = 4'h9;
    localparam logic [3:0] FMT_SDATA2  = 4'hA;
    localparam logic [3:0] FMT_SDATA4  = 4'hB;
    localparam logic [3:0] FMT_SDATA8  = 4'hC;

    localparam logic [2:0] REL_ABS = 3'd0;
    localparam logic [2:0] REL_PC  = 3'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OMITTED   = 3'd1,
        ST_BAD_FMT   = 3'd2,
        ST_BAD_REL   = 3'd3,
        ST_OVERLONG  = 3'd4
    } status_t;

    typedef struct packed {
        logic        in_field;
        logic [3:0]  bytes_seen;
        logic [63:0] accumulator;
        logic [63:0] field_base;
    } field_state_t;

    typedef struct packed {
        logic        field_done;
        logic [63:0] value;
        status_t     status;
        logic        indirect;
    } field_result_t;

endpackage

// ===== rtl/core/dwarfptr_step.sv =====
// Combinational per-byte decode step: folds one byte into the field state.
// Depends on dwarfptr_pkg.
module dwarfptr_step import dwarfptr_pkg::*; (
    input  logic [7:0]    data_byte,
    input  logic [63:0]   field_address,
    input  logic [7:0]    encoding,
    input  field_state_t  cur,
    output field_state_t  nxt,
    output field_result_t res
);

    localparam logic [3:0] PTR_N   = 4'(POINTER_BYTES);
    localparam logic [3:0] LEB_MAX = 4'(MAX_LEB_BYTES - 1);

    logic [3:0]  fmt;
    logic [2:0]  rel;
    logic        is_leb;
    logic        fmt_bad;
    logic [3:0]  fix_n;
    logic [3:0]  bs;
    logic [63:0] acc;
    logic [63:0] base;
    logic [6:0]  leb_sh;
    logic [6:0]  leb_sh_fill;
    logic [63:0] leb_acc;
    logic [63:0] fix_acc;
    logic [63:0] fix_mask;
    logic [63:0] fix_cut;
    logic        fix_done;
    logic        leb_last;
    logic        leb_over;
    logic        done;
    logic [63:0] sum;

    assign fmt = encoding[3:0];
    assign rel = encoding[6:4];

    always_comb begin
        is_leb  = 1'b0;
        fmt_bad = 1'b0;
        fix_n   = 4'd8;
        unique case (fmt) inside
            FMT_ABSPTR:               fix_n  = PTR_N;
            FMT_ULEB128, FMT_SLEB128: is_leb = 1'b1;
            FMT_UDATA2, FMT_SDATA2:   fix_n  = 4'd2;
            FMT_UDATA4, FMT_SDATA4:   fix_n  = 4'd4;
            FMT_UDATA8, FMT_SDATA8:   fix_n  = 4'd8;
            default:                  fmt_bad = 1'b1;
        endcase
    end

    assign bs   = cur.in_field ? cur.bytes_seen  : 4'd0;
    assign acc  = cur.in_field ? cur.accumulator : 64'd0;
    assign base = cur.in_field ? cur.field_base  : field_address;

    // LEB128: seven payload bits per byte, sign fill above the last group
    assign leb_sh      = {3'd0, bs} * 7'd7;
    assign leb_sh_fill = leb_sh + 7'd7;
    assign leb_last    = !data_byte[7];
    assign leb_over    = data_byte[7] && (bs >= LEB_MAX);

    always_comb begin
        leb_acc = acc | (64'(data_byte[6:0]) << leb_sh);
        if (leb_last && fmt == FMT_SLEB128 && data_byte[6]) begin
            leb_acc = leb_acc | (~64'd0 << leb_sh_fill);
        end
    end

    // Fixed little-endian forms
    assign fix_done = ({1'b0, bs} + 5'd1) >= {1'b0, fix_n};
    assign fix_mask = (fix_n < 4'd8) ? ((64'd1 << {fix_n, 3'd0}) - 64'd1) : ~64'd0;

    always_comb begin
        fix_acc = acc;
        if (!bs[3]) begin
            fix_acc = acc | (64'(data_byte) << {bs[2:0], 3'd0});
        end
        fix_cut = fix_acc & fix_mask;
        if (fmt[3] && |(fix_cut & (fix_mask ^ (fix_mask >> 1))) && fix_n < 4'd8) begin
            fix_cut = fix_cut | ~fix_mask;
        end
    end

    assign done = is_leb ? leb_last : fix_done;
    assign sum  = (is_leb ? leb_acc : fix_cut) + ((rel == REL_PC) ? base : 64'd0);

    always_comb begin
        nxt = '0;
        res = '{field_done: 1'b0, value: 64'd0, status: ST_OK, indirect: 1'b0};
        if (encoding == ENC_OMIT) begin
            res.field_done = 1'b1;
            res.status     = ST_OMITTED;
        end else if (fmt_bad) begin
            res.field_done = 1'b1;
            res.status     = ST_BAD_FMT;
        end else if (rel != REL_ABS && rel != REL_PC) begin
            res.field_done = 1'b1;
            res.status     = ST_BAD_REL;
        end else if (is_leb && leb_over) begin
            res.field_done = 1'b1;
            res.status     = ST_OVERLONG;
        end else if (done) begin
            res.field_done = 1'b1;
            res.value      = sum;
            res.indirect   = encoding[7];
        end else begin
            nxt.in_field    = 1'b1;
            nxt.bytes_seen  = bs + 4'd1;
            nxt.accumulator = is_leb ? leb_acc : fix_acc;
            nxt.field_base  = base;
        end
    end

endmodule

// ===== rtl/core/dwarf_encoded_pointer_decoder.sv =====
// Top level of the DWARF encoded pointer decoder: input register, field
// state, result register. Depends on dwarfptr_pkg and dwarfptr_step.
//
//   channel  ports                                      dir  request
//   s_       s_data_byte, s_field_address               in   one raw byte
//   m_       m_field_done, m_value, m_status, m_indirect out  one result per byte
//   cfg      encoding_we, encoding_wdata                in   encoding register write
//
// One byte per cycle while m_ready stays high; m_valid rises when res_reg loads.
// The decode of a byte is one pass through dwarfptr_step between the input
// register and the result register; field state updates as the byte moves on.
// Synchronous active-low reset empties both registers, clears the field state
// and sets encoding to omitted. A stalled m_ side holds the result while the
// input register still takes one more byte.
module dwarf_encoded_pointer_decoder import dwarfptr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        encoding_we,
    input  logic [7:0]  encoding_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [63:0] s_field_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_field_done,
    output logic [63:0] m_value,
    output logic [2:0]  m_status,
    output logic        m_indirect
);

    logic [7:0]    encoding_reg;
    logic          in_valid_reg;
    logic [7:0]    in_data_reg;
    logic [63:0]   in_addr_reg;
    field_state_t  state_reg;
    field_state_t  state_next;
    field_result_t res_next;
    field_result_t res_reg;
    logic          m_valid_reg;
    logic          advance;

    dwarfptr_step u_step (
        .data_byte     (in_data_reg),
        .field_address (in_addr_reg),
        .encoding      (encoding_reg),
        .cur           (state_reg),
        .nxt           (state_next),
        .res           (res_next)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            encoding_reg <= ENC_OMIT;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (encoding_we) begin
                encoding_reg <= encoding_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_addr_reg <= s_field_address;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_field_done = res_reg.field_done;
    assign m_value      = res_reg.value;
    assign m_status     = res_reg.status;
    assign m_indirect   = res_reg.indirect;

    a_err_ends_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_field_done && m_value == 64'd0)
        else $error("error status without field end");

    a_partial_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_field_done |-> m_value == 64'd0 && m_status == ST_OK && !m_indirect)
        else $error("partial field result not zero");

    a_idle_state_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.in_field |-> state_reg.bytes_seen == 4'd0)
        else $error("byte count kept outside a field");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bytes_seen <= 4'(MAX_LEB_BYTES - 1))
        else $error("byte count out of range");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_next.field_done |=> !state_reg.in_field)
        else $error("field state kept after completion");

endmodule
